// ===== sv/dcs_pkg.sv =====
// Shared types, opcodes and constants for the dynamic capacity stack.
package dcs_pkg;

    localparam int DCS_DEPTH        = 1024;
    localparam int DCS_RESET_CAP    = 4;
    localparam int DCS_WORD_W       = 32;
    localparam int DCS_OPCODE_W     = 3;

    typedef enum logic [DCS_OPCODE_W-1:0] {
        OP_PUSH     = 3'd0,
        OP_POP      = 3'd1,
        OP_PEEK     = 3'd2,
        OP_READ     = 3'd3,
        OP_CONTAINS = 3'd4,
        OP_CLEAR    = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_RESP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic scan;
    } dcs_cmd_t;

endpackage

// ===== sv/dcs_ctrl.sv =====
// Controller state machine that sequences request execution and the search walk.
module dcs_ctrl
    import dcs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [DCS_OPCODE_W-1:0] opcode,
    input  logic                    scan_done,
    output logic                    busy,
    output logic                    done,
    output dcs_cmd_t                cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE, ST_RESP:
            begin
                if (start)
                begin
                    state_next = (opcode == OP_CONTAINS) ? ST_SCAN : ST_EXEC;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_RESP;
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_RESP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy     = 1'b0;
        done     = 1'b0;
        cmd.exec = 1'b0;
        cmd.scan = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_EXEC:
            begin
                busy     = 1'b1;
                cmd.exec = 1'b1;
            end
            ST_SCAN:
            begin
                busy     = 1'b1;
                cmd.scan = 1'b1;
            end
            ST_RESP:
            begin
                done = 1'b1;
            end
            default:
            begin
            end
        endcase
        cmd.load = accept;
    end

endmodule

// ===== sv/dcs_dp.sv =====
// Datapath: word memory, count and capacity registers, search walk and result registers.
module dcs_dp
    import dcs_pkg::*;
#(
    parameter int DEPTH = DCS_DEPTH,
    localparam int CW   = $clog2(DEPTH + 1),
    localparam int AW   = $clog2(DEPTH)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  dcs_cmd_t                cmd,
    input  logic                    cfg_we,
    input  logic [CW-1:0]           cfg_data,
    input  logic [DCS_OPCODE_W-1:0] opcode,
    input  logic signed [DCS_WORD_W-1:0] value,
    input  logic [AW-1:0]           position,
    output logic                    scan_done,
    output logic signed [DCS_WORD_W-1:0] data,
    output logic                    success,
    output logic                    found,
    output logic [CW-1:0]           count,
    output logic [CW-1:0]           capacity
);

    localparam int          RESET_CAP = (DCS_RESET_CAP < DEPTH) ? DCS_RESET_CAP : DEPTH;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW:0]   DEPTH_W = (CW + 1)'(DEPTH);

    logic [DCS_WORD_W-1:0] mem_reg [DEPTH];
    logic [DCS_WORD_W-1:0] rd_data_reg;

    logic [DCS_OPCODE_W-1:0] op_reg;
    logic [DCS_WORD_W-1:0]   value_reg;
    logic [AW-1:0]           pos_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] cap_reg, cap_next;
    logic [CW-1:0] scan_idx_reg, scan_idx_next;
    logic          pend_reg, pend_next;
    logic          hit_reg, hit_next;
    logic          ok_reg, ok_next;
    logic          sel_reg, sel_next;

    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;

    logic [CW:0]   cap_dbl;
    logic [CW-1:0] count_dec;
    logic          hit_now;

    assign cap_dbl   = {cap_reg, 1'b0};
    assign count_dec = count_reg - CW'(1);
    assign hit_now   = pend_reg && (rd_data_reg == value_reg);
    assign scan_done = hit_now || (scan_idx_reg >= count_reg);

    always_comb
    begin
        count_next    = count_reg;
        cap_next      = cap_reg;
        scan_idx_next = scan_idx_reg;
        pend_next     = pend_reg;
        hit_next      = hit_reg;
        ok_next       = ok_reg;
        sel_next      = sel_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_waddr     = count_reg[AW-1:0];
        mem_raddr     = count_dec[AW-1:0];

        // A register write reinitializes the stack; a request taken in the same
        // cycle then runs on the reinitialized stack.
        if (cfg_we)
        begin
            count_next = '0;
            if (cfg_data == '0)
            begin
                cap_next = CW'(1);
            end
            else if (cfg_data > DEPTH_C)
            begin
                cap_next = DEPTH_C;
            end
            else
            begin
                cap_next = cfg_data;
            end
        end

        if (cmd.load)
        begin
            scan_idx_next = '0;
            pend_next     = 1'b0;
            hit_next      = 1'b0;
            ok_next       = (opcode == OP_CONTAINS);
            sel_next      = 1'b0;
        end
        else if (cmd.exec)
        begin
            unique case (op_reg)
                OP_PUSH:
                begin
                    if (count_reg < cap_reg)
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                        ok_next    = 1'b1;
                    end
                    else if (cap_dbl <= DEPTH_W)
                    begin
                        // Full: grow the capacity, then store.
                        cap_next   = cap_dbl[CW-1:0];
                        mem_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                        ok_next    = 1'b1;
                    end
                end
                OP_POP:
                begin
                    if (count_reg != '0)
                    begin
                        mem_re     = 1'b1;
                        count_next = count_dec;
                        ok_next    = 1'b1;
                        sel_next   = 1'b1;
                        if (!cap_reg[0] && (cap_reg >= CW'(2)) &&
                            (count_dec <= (cap_reg >> 1)))
                        begin
                            cap_next = cap_reg >> 1;
                        end
                    end
                end
                OP_PEEK:
                begin
                    if (count_reg != '0)
                    begin
                        mem_re   = 1'b1;
                        ok_next  = 1'b1;
                        sel_next = 1'b1;
                    end
                end
                OP_READ:
                begin
                    mem_raddr = pos_reg;
                    if (CW'(pos_reg) < count_reg)
                    begin
                        mem_re   = 1'b1;
                        ok_next  = 1'b1;
                        sel_next = 1'b1;
                    end
                end
                OP_CLEAR:
                begin
                    count_next = '0;
                    ok_next    = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.scan)
        begin
            // One read issued and one earlier read compared per cycle.
            mem_raddr = scan_idx_reg[AW-1:0];
            hit_next  = hit_reg || hit_now;
            if (!scan_done)
            begin
                mem_re        = 1'b1;
                scan_idx_next = scan_idx_reg + CW'(1);
                pend_next     = 1'b1;
            end
            else
            begin
                pend_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            cap_reg      <= CW'(RESET_CAP);
            scan_idx_reg <= '0;
            pend_reg     <= 1'b0;
            hit_reg      <= 1'b0;
            ok_reg       <= 1'b0;
            sel_reg      <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            cap_reg      <= cap_next;
            scan_idx_reg <= scan_idx_next;
            pend_reg     <= pend_next;
            hit_reg      <= hit_next;
            ok_reg       <= ok_next;
            sel_reg      <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= opcode;
            value_reg <= value;
            pos_reg   <= position;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_reg[mem_waddr] <= value_reg;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem_reg[mem_raddr];
        end
    end

    assign data     = sel_reg ? signed'(rd_data_reg) : '0;
    assign success  = ok_reg;
    assign found    = hit_reg;
    assign count    = count_reg;
    assign capacity = cap_reg;

endmodule

// ===== sv/dynamic_capacity_stack_top.sv =====
// Top level of the dynamic capacity stack: controller plus datapath.
// Push, pop, peek, read and clear pass through ST_EXEC and show their result in ST_RESP;
// contains compares the stored words in ST_SCAN, one per cycle, and ends early on a match.
// A new request may be started in the cycle its predecessor's result is shown.
// Results cannot be stalled.
// Reset (rst_n low, asynchronous): count 0, capacity 4; memory contents stay undefined.
module dynamic_capacity_stack_top
    import dcs_pkg::*;
#(
    parameter int DEPTH = DCS_DEPTH,
    localparam int CW   = $clog2(DEPTH + 1),
    localparam int AW   = $clog2(DEPTH)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [DCS_OPCODE_W-1:0] opcode,
    input  logic signed [DCS_WORD_W-1:0] value,
    input  logic [AW-1:0]           position,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CW-1:0]           cfg_data,
    output logic                    done,
    output logic signed [DCS_WORD_W-1:0] data,
    output logic                    success,
    output logic                    found,
    output logic [CW-1:0]           count,
    output logic [CW-1:0]           capacity
);

    dcs_cmd_t cmd;
    logic     scan_done;

    assign cfg_ready = !busy;

    dcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .opcode    (opcode),
        .scan_done (scan_done),
        .busy      (busy),
        .done      (done),
        .cmd       (cmd)
    );

    dcs_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .opcode    (opcode),
        .value     (value),
        .position  (position),
        .scan_done (scan_done),
        .data      (data),
        .success   (success),
        .found     (found),
        .count     (count),
        .capacity  (capacity)
    );

endmodule
